@@ rtl/xzre_pkg.sv @@
// ----------------------------------------------------------------------------
// xzre_pkg
// Shared types, constants and control structs for the xor zero-run encoder.
// ----------------------------------------------------------------------------
package xzre_pkg;

  localparam int unsigned MemSpan  = 4096;
  localparam int unsigned RunW     = $clog2(MemSpan + 1);
  localparam int unsigned RunChunk = 256;

  localparam logic [1:0] ActBegin = 2'd0;
  localparam logic [1:0] ActData  = 2'd1;
  localparam logic [1:0] ActEnd   = 2'd2;

  localparam logic [1:0] SelHdr  = 2'd0;
  localparam logic [1:0] SelZero = 2'd1;
  localparam logic [1:0] SelCnt  = 2'd2;
  localparam logic [1:0] SelByte = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  current_byte;
    logic [7:0]  original_byte;
    logic        original_valid;
    logic [31:0] image_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       load_len;
    logic       clr_run;
    logic       inc_run;
    logic       load_ch;
    logic       emit;
    logic [1:0] sel;
    logic       hdr_next;
    logic       run_sub;
  } cmd_t;

  typedef struct packed {
    logic ch_zero;
    logic run_zero;
    logic run_le_chunk;
    logic hdr_last;
    logic slot_free;
  } stat_t;

endpackage

@@ rtl/xor_zero_run_encoder.sv @@
// ----------------------------------------------------------------------------
// xor_zero_run_encoder
// Compresses a memory image against its original as xor bytes and zero runs.
// ----------------------------------------------------------------------------
// An item is taken while the encoder is idle. A zero data byte, an end item
// or an unknown action produces nothing and leaves the encoder idle. A begin
// item writes the four-byte big-endian length header. A nonzero data byte
// after a pending run of n zeros writes ceil(n/256) run pairs, each a zero
// byte and a count byte, and then the byte; input is stalled meanwhile.
// Each output byte waits until the single output register is free, so a
// stalled consumer holds the encoder. Zero runs saturate at 4096 bytes.
module xor_zero_run_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xzre_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xzre_pkg::out_item_t out_o
);

  xzre_pkg::cmd_t  cmd;
  xzre_pkg::stat_t stat;

  xzre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_i.action),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  xzre_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

@@ rtl/xzre_dpath.sv @@
// ----------------------------------------------------------------------------
// xzre_dpath
// Datapath: header length, pending byte, zero-run count and output register.
// ----------------------------------------------------------------------------
module xzre_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xzre_pkg::in_item_t  in_i,
  input  xzre_pkg::cmd_t      cmd_i,
  output xzre_pkg::stat_t     stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output xzre_pkg::out_item_t out_o
);

  localparam logic [xzre_pkg::RunW-1:0] Chunk = xzre_pkg::RunW'(xzre_pkg::RunChunk);
  localparam logic [xzre_pkg::RunW-1:0] Span  = xzre_pkg::RunW'(xzre_pkg::MemSpan);
  localparam logic [xzre_pkg::RunW-1:0] One   = xzre_pkg::RunW'(1);

  logic [31:0]               len_q;
  logic [7:0]                ch_q;
  logic [7:0]                ch_in;
  logic [xzre_pkg::RunW-1:0] run_q, run_d;
  logic [1:0]                hdr_q;
  logic                      out_valid_q, out_valid_d;
  xzre_pkg::out_item_t       out_q, out_d;
  logic                      run_ge_chunk;
  logic [7:0]                hdr_byte;

  assign ch_in        = in_i.original_valid ? (in_i.current_byte ^ in_i.original_byte)
                                            : in_i.current_byte;
  assign run_ge_chunk = (run_q >= Chunk);

  assign stat_o.ch_zero      = (ch_in == 8'd0);
  assign stat_o.run_zero     = (run_q == '0);
  assign stat_o.run_le_chunk = (run_q <= Chunk);
  assign stat_o.hdr_last     = (hdr_q == 2'd3);
  assign stat_o.slot_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (hdr_q)
      2'd0:    hdr_byte = len_q[31:24];
      2'd1:    hdr_byte = len_q[23:16];
      2'd2:    hdr_byte = len_q[15:8];
      default: hdr_byte = len_q[7:0];
    endcase
  end

  always_comb begin
    run_d = run_q;
    if (cmd_i.clr_run) begin
      run_d = '0;
    end else if (cmd_i.inc_run) begin
      if (run_q < Span) begin
        run_d = run_q + One;
      end
    end else if (cmd_i.run_sub) begin
      run_d = run_ge_chunk ? (run_q - Chunk) : '0;
    end
  end

  always_comb begin
    out_d = out_q;
    unique case (cmd_i.sel)
      xzre_pkg::SelHdr: begin
        out_d.out_byte    = hdr_byte;
        out_d.last_of_run = (hdr_q == 2'd3);
      end
      xzre_pkg::SelZero: begin
        out_d.out_byte    = 8'd0;
        out_d.last_of_run = 1'b0;
      end
      xzre_pkg::SelCnt: begin
        out_d.out_byte    = run_ge_chunk ? 8'hff : (run_q[7:0] - 8'd1);
        out_d.last_of_run = 1'b0;
      end
      default: begin
        out_d.out_byte    = ch_q;
        out_d.last_of_run = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      hdr_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.load_len) begin
        hdr_q <= 2'd0;
      end else if (cmd_i.hdr_next) begin
        hdr_q <= hdr_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_len) begin
      len_q <= in_i.image_length;
    end
    if (cmd_i.load_ch) begin
      ch_q <= ch_in;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ rtl/xzre_ctrl.sv @@
// ----------------------------------------------------------------------------
// xzre_ctrl
// Controller: accepts items and sequences header, run pairs and literal byte.
// ----------------------------------------------------------------------------
module xzre_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      action_i,
  output logic            in_stall_o,
  input  xzre_pkg::stat_t stat_i,
  output xzre_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StHdr   = 3'd1;
  localparam logic [2:0] StRZero = 3'd2;
  localparam logic [2:0] StRCnt  = 3'd3;
  localparam logic [2:0] StByte  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = xzre_pkg::SelHdr;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (action_i)
            xzre_pkg::ActBegin: begin
              cmd_o.load_len = 1'b1;
              cmd_o.clr_run  = 1'b1;
              state_d        = StHdr;
            end
            xzre_pkg::ActEnd: begin
              cmd_o.clr_run = 1'b1;
            end
            xzre_pkg::ActData: begin
              if (stat_i.ch_zero) begin
                cmd_o.inc_run = 1'b1;
              end else begin
                cmd_o.load_ch = 1'b1;
                state_d       = stat_i.run_zero ? StByte : StRZero;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StHdr: begin
        cmd_o.sel = xzre_pkg::SelHdr;
        if (stat_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.hdr_next = 1'b1;
          if (stat_i.hdr_last) begin
            state_d = StIdle;
          end
        end
      end
      StRZero: begin
        cmd_o.sel = xzre_pkg::SelZero;
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StRCnt;
        end
      end
      StRCnt: begin
        cmd_o.sel = xzre_pkg::SelCnt;
        if (stat_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.run_sub = 1'b1;
          state_d       = stat_i.run_le_chunk ? StByte : StRZero;
        end
      end
      StByte: begin
        cmd_o.sel = xzre_pkg::SelByte;
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
